/* hdl/ksa_pkg.sv */
// Shared types, constants and codes for the keyed input slot assigner.
`default_nettype none

package ksa_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int MAX_INPUTS  = 1024;

    localparam int KEY_W    = 64;
    localparam int OFF_W    = 10;
    localparam int SLOTF_W  = 8;
    localparam int SIG_W    = 16;
    localparam int LIMB_W   = 64;
    localparam int STATUS_W = 3;
    localparam int REM_W    = 11;
    localparam int OP_W     = 2;
    localparam int ID_W     = SIG_W + 1;

    localparam int TSIZE_W  = 9;
    localparam int ICOUNT_W = 11;
    localparam int ISTART_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int SLOT_AW  = $clog2(TABLE_DEPTH);
    localparam int EFF_W    = $clog2(TABLE_DEPTH + 1);
    localparam int IN_EFF_W = $clog2(MAX_INPUTS + 1);

    localparam int MARK_W    = 32;
    localparam int MARK_CW   = $clog2(MARK_W);
    localparam int MARK_ROWS = (MAX_INPUTS + MARK_W - 1) / MARK_W;
    localparam int ROW_AW    = (MARK_ROWS > 1) ? $clog2(MARK_ROWS) : 1;
    localparam int MARK_IW   = MARK_CW + ROW_AW;

    localparam int MOD_STEP = 8;
    localparam int MOD_CYC  = KEY_W / MOD_STEP;
    localparam int MOD_CW   = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

    localparam int IN_BITS     = KEY_W + OFF_W + SLOTF_W + SIG_W + 4 * LIMB_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = SIG_W + 1 + 4 * LIMB_W + 1 + REM_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_START = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ARM    = 2'd1,
        OP_ASSIGN = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_NONE_LEFT = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_TWICE     = 3'd3,
        STS_RANGE     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_MOD,
        S_PROBE,
        S_CALC,
        S_MARK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [LIMB_W-1:0]  value_limb3;
        logic [LIMB_W-1:0]  value_limb2;
        logic [LIMB_W-1:0]  value_limb1;
        logic [LIMB_W-1:0]  value_limb0;
        logic [SIG_W-1:0]   slot_signal;
        logic [SLOTF_W-1:0] slot;
        logic [OFF_W-1:0]   element_offset;
        logic [KEY_W-1:0]   key_hash;
    } in_fields_t;

    typedef struct packed {
        logic [REM_W-1:0]  remaining;
        logic              all_assigned;
        logic [LIMB_W-1:0] out_limb3;
        logic [LIMB_W-1:0] out_limb2;
        logic [LIMB_W-1:0] out_limb1;
        logic [LIMB_W-1:0] out_limb0;
        logic              write_enable;
        logic [SIG_W-1:0]  signal_id;
    } out_fields_t;

    typedef struct packed {
        logic [KEY_W-1:0] hash;
        logic [SIG_W-1:0] base;
    } slot_entry_t;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [SLOT_AW-1:0] addr;
        slot_entry_t        wdata;
    } slot_req_t;

    typedef struct packed {
        logic              clr;
        logic              rd;
        logic              wr;
        logic [ROW_AW-1:0] row;
        logic [MARK_W-1:0] wdata;
    } mark_req_t;

endpackage

`default_nettype wire

/* hdl/ksa_hash_mod.sv */
// Iterative remainder of the key hash by the table size, a few bits per cycle.
`default_nettype none

module ksa_hash_mod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ksa_pkg::KEY_W-1:0]   dividend,
    input  wire logic [ksa_pkg::EFF_W-1:0]   divisor,
    output logic                             done,
    output logic [ksa_pkg::SLOT_AW-1:0]      rem
);
    import ksa_pkg::*;

    localparam int RW = EFF_W + 1;

    logic              busy_reg;
    logic              done_reg;
    logic [MOD_CW-1:0] cnt_reg;
    logic [KEY_W-1:0]  sh_reg;
    logic [RW-1:0]     r_reg;
    logic [RW-1:0]     r_next;

    always_comb
    begin
        logic [RW-1:0]       r;
        logic [MOD_STEP-1:0] bits;
        r = r_reg;
        bits = sh_reg[KEY_W-1 -: MOD_STEP];
        for (int i = 0; i < MOD_STEP; i++)
        begin
            r = {r[RW-2:0], bits[MOD_STEP-1-i]};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
            end
        end
        r_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == MOD_CW'(MOD_CYC - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MOD_CW'(MOD_CYC - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg <= dividend;
            r_reg  <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg <= sh_reg << MOD_STEP;
            r_reg  <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = SLOT_AW'(r_reg);

endmodule

`default_nettype wire

/* hdl/ksa_slot_table.sv */
// Hash table slot memory with per-slot valid bits; empty slots read as zero.
`default_nettype none

module ksa_slot_table (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ksa_pkg::slot_req_t    req,
    output ksa_pkg::slot_entry_t       rdata
);
    import ksa_pkg::*;

    slot_entry_t mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    slot_entry_t rd_reg;
    logic        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rd_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;

endmodule

`default_nettype wire

/* hdl/ksa_mark_store.sv */
// Assigned-mark memory in rows of bits, with a row-per-cycle clearing pass.
`default_nettype none

module ksa_mark_store (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ksa_pkg::mark_req_t            req,
    output logic                               busy,
    output logic [ksa_pkg::MARK_W-1:0]         rdata
);
    import ksa_pkg::*;

    logic [MARK_W-1:0] mem [MARK_ROWS];
    logic [MARK_W-1:0] rd_reg;
    logic              clr_busy_reg;
    logic [ROW_AW-1:0] clr_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (req.clr)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_AW'(MARK_ROWS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_row_reg] <= '0;
        end
        else if (req.wr)
        begin
            mem[req.row] <= req.wdata;
        end
        if (req.rd)
        begin
            rd_reg <= mem[req.row];
        end
    end

    assign busy  = clr_busy_reg;
    assign rdata = rd_reg;

endmodule

`default_nettype wire

/* hdl/keyed_input_slot_assigner.sv */
// Top level: resolves name hashes to input signal ids and tracks assignment.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tuser op, s_tdata item fields
//  m_*     | out | m_tvalid/m_tready  | m_tuser status, m_tdata result fields
//  cfg_*   | in  | cfg_we             | cfg_index register, cfg_data value
//
// One item at a time. Load and no-op finish straight after dispatch, arm clears the mark
// memory (one row per cycle), and assign probes the slots after a modulo by the table size,
// one slot memory read per cycle.
// After reset a clearing pass over the mark memory runs before the first beat.
// The result sits in an output register; the next beat is taken while it waits.
`default_nettype none

module keyed_input_slot_assigner (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // key_hash, element_offset, slot, slot_signal, value_limb0..3, zero pad
    input  wire logic [ksa_pkg::IN_TDATA_W-1:0]     s_tdata,
    // op
    input  wire logic [ksa_pkg::OP_W-1:0]           s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // signal_id, write_enable, out_limb0..3, all_assigned, remaining, zero pad
    output logic [ksa_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // status
    output logic [ksa_pkg::STATUS_W-1:0]            m_tuser,
    input  wire logic                               cfg_we,
    input  wire logic [ksa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ksa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ksa_pkg::*;

    state_t state_reg, state_next;

    logic [TSIZE_W-1:0]  ts_reg;
    logic [ICOUNT_W-1:0] ic_reg;
    logic [ISTART_W-1:0] is_reg;

    in_fields_t          item_reg;
    op_t                 op_reg;
    logic [IN_EFF_W-1:0] left_reg;
    logic [SLOT_AW-1:0]  pos_reg;
    logic [EFF_W-1:0]    steps_reg;
    logic [SIG_W-1:0]    base_reg;
    logic [MARK_IW-1:0]  idx_reg;
    status_t             res_status_reg;
    logic [SIG_W-1:0]    res_sig_reg;
    logic                res_we_reg;
    logic                res_done_reg;
    out_fields_t         out_reg;
    status_t             out_status_reg;
    logic                m_tvalid_reg;

    logic [EFF_W-1:0]    eff_ts;
    logic [IN_EFF_W-1:0] eff_ic;
    logic [EFF_W-1:0]    pos_inc;
    logic [SLOT_AW-1:0]  pos_next;
    logic [EFF_W-1:0]    steps_inc;
    logic                probe_hit;
    logic                probe_miss;
    logic [ID_W-1:0]     id_sum;
    logic [ID_W-1:0]     id_diff;
    logic                id_bad;
    logic [MARK_CW-1:0]  mark_col;
    logic                mark_bit;
    logic                fin_load;
    logic                accept;
    logic                mod_start;
    logic                mod_done;
    logic [SLOT_AW-1:0]  mod_rem;
    slot_req_t           slot_req;
    slot_entry_t         slot_rdata;
    mark_req_t           mark_req;
    logic                mark_busy;
    logic [MARK_W-1:0]   mark_rdata;

    ksa_hash_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (item_reg.key_hash),
        .divisor  (eff_ts),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    ksa_slot_table u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (slot_req),
        .rdata (slot_rdata)
    );

    ksa_mark_store u_marks (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mark_req),
        .busy  (mark_busy),
        .rdata (mark_rdata)
    );

    // effective register values
    always_comb
    begin
        if (ts_reg == '0)
        begin
            eff_ts = EFF_W'(1);
        end
        else if (32'(ts_reg) > TABLE_DEPTH)
        begin
            eff_ts = EFF_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_ts = EFF_W'(ts_reg);
        end

        if (32'(ic_reg) > MAX_INPUTS)
        begin
            eff_ic = IN_EFF_W'(MAX_INPUTS);
        end
        else
        begin
            eff_ic = IN_EFF_W'(ic_reg);
        end
    end

    // probe step and id checks
    assign pos_inc    = EFF_W'(pos_reg) + 1'b1;
    assign pos_next   = (pos_inc == eff_ts) ? '0 : SLOT_AW'(pos_inc);
    assign steps_inc  = steps_reg + 1'b1;
    assign probe_hit  = (slot_rdata.hash == item_reg.key_hash);
    assign probe_miss = (slot_rdata.hash == '0) || (steps_inc == eff_ts);

    assign id_sum  = {1'b0, base_reg} + ID_W'(item_reg.element_offset);
    assign id_diff = id_sum - {1'b0, is_reg};
    assign id_bad  = id_sum[SIG_W] || (id_sum < {1'b0, is_reg}) ||
                     (id_diff >= ID_W'(eff_ic));

    assign mark_col = idx_reg[MARK_CW-1:0];
    assign mark_bit = mark_rdata[mark_col];

    assign accept   = s_tvalid && s_tready;
    assign fin_load = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (op_reg)
                    OP_ARM:
                    begin
                        state_next = S_CLEAR;
                    end
                    OP_ASSIGN:
                    begin
                        if (left_reg == '0 || item_reg.key_hash == '0)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_MOD;
                        end
                    end
                    OP_LOAD, OP_NOP:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_CLEAR:
            begin
                if (!mark_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (probe_hit)
                begin
                    state_next = S_CALC;
                end
                else if (probe_miss)
                begin
                    state_next = S_FINISH;
                end
            end
            S_CALC:
            begin
                state_next = id_bad ? S_FINISH : S_MARK;
            end
            S_MARK:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (fin_load)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // control outputs to the memories and the modulo unit
    always_comb
    begin
        s_tready       = 1'b0;
        mod_start      = 1'b0;
        slot_req       = '0;
        mark_req       = '0;
        slot_req.wdata = '{hash: item_reg.key_hash, base: item_reg.slot_signal};
        mark_req.row   = idx_reg[MARK_IW-1:MARK_CW];
        mark_req.wdata = mark_rdata;
        mark_req.wdata[mark_col] = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = !mark_busy;
            end
            S_DISPATCH:
            begin
                slot_req.addr = SLOT_AW'(item_reg.slot);
                if (op_reg == OP_LOAD && 32'(item_reg.slot) < TABLE_DEPTH)
                begin
                    slot_req.wr = 1'b1;
                end
                if (op_reg == OP_ARM)
                begin
                    mark_req.clr = 1'b1;
                end
                if (op_reg == OP_ASSIGN && left_reg != '0 && item_reg.key_hash != '0)
                begin
                    mod_start = 1'b1;
                end
            end
            S_MOD:
            begin
                slot_req.addr = mod_rem;
                slot_req.rd   = mod_done;
            end
            S_PROBE:
            begin
                slot_req.addr = pos_next;
                slot_req.rd   = !probe_hit && !probe_miss;
            end
            S_CALC:
            begin
                mark_req.row = id_diff[MARK_IW-1:MARK_CW];
                mark_req.rd  = !id_bad;
            end
            S_MARK:
            begin
                mark_req.wr = !mark_bit;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ts_reg       <= TSIZE_W'(256);
            ic_reg       <= '0;
            is_reg       <= ISTART_W'(1);
            left_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                priority case (cfg_index)
                    CFG_TABLE_SIZE:  ts_reg <= cfg_data[TSIZE_W-1:0];
                    CFG_INPUT_COUNT: ic_reg <= cfg_data[ICOUNT_W-1:0];
                    CFG_INPUT_START: is_reg <= cfg_data[ISTART_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == S_DISPATCH && op_reg == OP_ARM)
            begin
                left_reg <= eff_ic;
            end
            else if (state_reg == S_MARK && !mark_bit)
            begin
                left_reg <= left_reg - 1'b1;
            end

            if (fin_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_reg <= in_fields_t'(s_tdata[IN_BITS-1:0]);
                    op_reg   <= op_t'(s_tuser);
                end
            end
            S_DISPATCH:
            begin
                res_status_reg <= STS_OK;
                res_sig_reg    <= '0;
                res_we_reg     <= 1'b0;
                res_done_reg   <= 1'b0;
                if (op_reg == OP_ASSIGN)
                begin
                    if (left_reg == '0)
                    begin
                        res_status_reg <= STS_NONE_LEFT;
                    end
                    else if (item_reg.key_hash == '0)
                    begin
                        res_status_reg <= STS_NOT_FOUND;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    pos_reg   <= mod_rem;
                    steps_reg <= '0;
                end
            end
            S_PROBE:
            begin
                if (probe_hit)
                begin
                    base_reg <= slot_rdata.base;
                end
                else if (probe_miss)
                begin
                    res_status_reg <= STS_NOT_FOUND;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    steps_reg <= steps_inc;
                end
            end
            S_CALC:
            begin
                res_sig_reg <= id_sum[SIG_W-1:0];
                idx_reg     <= id_diff[MARK_IW-1:0];
                if (id_bad)
                begin
                    res_status_reg <= STS_RANGE;
                end
            end
            S_MARK:
            begin
                if (mark_bit)
                begin
                    res_status_reg <= STS_TWICE;
                end
                else
                begin
                    res_we_reg   <= 1'b1;
                    res_done_reg <= (left_reg == IN_EFF_W'(1));
                end
            end
            S_FINISH:
            begin
                if (fin_load)
                begin
                    out_status_reg       <= res_status_reg;
                    out_reg.signal_id    <= res_sig_reg;
                    out_reg.write_enable <= res_we_reg;
                    out_reg.out_limb0    <= res_we_reg ? item_reg.value_limb0 : '0;
                    out_reg.out_limb1    <= res_we_reg ? item_reg.value_limb1 : '0;
                    out_reg.out_limb2    <= res_we_reg ? item_reg.value_limb2 : '0;
                    out_reg.out_limb3    <= res_we_reg ? item_reg.value_limb3 : '0;
                    out_reg.all_assigned <= res_done_reg;
                    out_reg.remaining    <= REM_W'(left_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);
    assign m_tuser  = out_status_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("beat taken while an item is in flight");

    a_we_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.write_enable) |-> (out_status_reg == STS_OK))
        else $error("write enable with error status");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= IN_EFF_W'(MAX_INPUTS))
        else $error("remaining count above input limit");

    a_left_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK && !mark_bit) |=> (left_reg == $past(left_reg) - 1'b1))
        else $error("remaining count not decremented on new mark");

endmodule

`default_nettype wire
